// ===== rtl/periodic_timer_slot_table_macros.svh =====
// ----------------------------------------------------------------------------
// Periodic timer slot table: assertion macros
// Shorthand for clocked assertions with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_SLOT_TABLE_MACROS_SVH
`define PERIODIC_TIMER_SLOT_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTST_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("periodic timer slot table: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("periodic timer slot table: assertion failed");

`endif

// ===== rtl/ptst_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer slot table: package
// Field widths, operation and status codes, slot entry and result types.
// ----------------------------------------------------------------------------
package ptst_pkg;

  localparam int DEF_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int FIRE_CW     = $clog2(MAX_RESULTS + 1);

  localparam int FUNC_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 3;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 24;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FIRED     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   due;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  slot_index;
    logic [HANDLE_W-1:0] handle;
  } result_t;

endpackage

// ===== rtl/ptst_ram.sv =====
// ----------------------------------------------------------------------------
// Periodic timer slot table: generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ptst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/periodic_timer_slot_table.sv =====
// ----------------------------------------------------------------------------
// Periodic timer slot table
// Timer slots with add, remove and tick operations; slot contents in a RAM.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                      tuser   tlast
//  s_*      in   handle, start_delay, period, now_tick      func    -
//  m_*      out  slot_index, fired_handle                   status  last
//
// Every item scans the slots one per cycle, unless stalled, through the single
// read port of the slot RAM; a tick visits every slot, an add or remove stops
// at the first free or matching slot.
// A stalled output holds the scan: a second firing waits while the output holds a result.
// Reset frees every slot at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
module periodic_timer_slot_table #(
  parameter int SLOTS = ptst_pkg::DEF_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // handle [15:0], start_delay [47:16], period [79:48], now_tick [111:80]
  input  logic [ptst_pkg::IN_DATA_W-1:0]   s_tdata,
  // func [1:0]
  input  logic [ptst_pkg::FUNC_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // slot_index [2:0], fired_handle [18:3], zero [23:19]
  output logic [ptst_pkg::OUT_DATA_W-1:0]  m_tdata,
  // status [2:0]
  output logic [ptst_pkg::STATUS_W-1:0]    m_tuser,
  output logic                             m_tlast
);

  import ptst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t state, state_next;

  logic [IW-1:0]      ev_idx, ev_idx_next;
  logic [SLOTS-1:0]   active, active_next;
  logic [FIRE_CW-1:0] fire_cnt, fire_cnt_next;
  logic               pend_valid, pend_valid_next;
  result_t            pend, pend_next;
  logic               out_valid, out_valid_next;
  result_t            out_res, out_res_next;
  logic               out_last, out_last_next;

  logic [FUNC_W-1:0]   op_func;
  logic [HANDLE_W-1:0] op_handle;
  logic [TIME_W-1:0]   op_due;
  logic [TIME_W-1:0]   op_period;
  logic [TIME_W-1:0]   op_now;

  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  slot_t         ram_wdata;
  slot_t         slot;

  logic          accept;
  logic          out_free;
  logic          act;
  logic          last_slot;
  logic          hit_add;
  logic          hit_rem;
  logic          fire;
  logic          stall;
  logic [IW+2:0] idx_ext;
  logic [INDEX_W-1:0] idx3;

  ptst_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ev_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (slot)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign act       = active[ev_idx];
  assign last_slot = (ev_idx == IW'(SLOTS - 1));
  assign idx_ext   = {3'b000, ev_idx};
  assign idx3      = idx_ext[INDEX_W-1:0];

  assign hit_add = (op_func == FUNC_ADD) && !act;
  assign hit_rem = (op_func == FUNC_REMOVE) && act && (slot.handle == op_handle);
  assign fire    = (op_func == FUNC_TICK) && act && !(op_now < slot.due) &&
                   (fire_cnt < FIRE_CW'(MAX_RESULTS));
  // A second firing must first push the held one out to the output register.
  assign stall   = fire && pend_valid && !out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_add || hit_rem) begin
          state_next = ST_FLUSH;
        end else if (!stall && last_slot) begin
          if (op_func == FUNC_ADD || op_func == FUNC_REMOVE || pend_valid || fire) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    ev_idx_next     = ev_idx;
    active_next     = active;
    fire_cnt_next   = fire_cnt;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    out_valid_next  = out_valid && !m_tready;
    out_res_next    = out_res;
    out_last_next   = out_last;
    ram_we          = 1'b0;
    ram_wdata       = slot;
    ram_raddr       = '0;

    case (state)
      ST_IDLE: begin
        ev_idx_next     = '0;
        fire_cnt_next   = '0;
        pend_valid_next = 1'b0;
      end
      ST_SCAN: begin
        if (stall) begin
          ram_raddr = ev_idx;
        end else begin
          ram_raddr   = last_slot ? '0 : ev_idx + IW'(1);
          ev_idx_next = last_slot ? '0 : ev_idx + IW'(1);
        end

        if (hit_add) begin
          ram_we              = 1'b1;
          ram_wdata.handle    = op_handle;
          ram_wdata.due       = op_due;
          ram_wdata.period    = op_period;
          active_next[ev_idx] = 1'b1;
          pend_valid_next     = 1'b1;
          pend_next           = '{STATUS_ADDED, idx3, op_handle};
        end else if (hit_rem) begin
          active_next[ev_idx] = 1'b0;
          pend_valid_next     = 1'b1;
          pend_next           = '{STATUS_REMOVED, idx3, op_handle};
        end else if (fire && !stall) begin
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_res_next   = pend;
            out_last_next  = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_next       = '{STATUS_FIRED, idx3, slot.handle};
          fire_cnt_next   = fire_cnt + FIRE_CW'(1);
          if (slot.period == '0) begin
            active_next[ev_idx] = 1'b0;
          end else begin
            ram_we        = 1'b1;
            ram_wdata.due = slot.due + slot.period;
          end
        end else if (last_slot) begin
          if (op_func == FUNC_ADD) begin
            pend_valid_next = 1'b1;
            pend_next       = '{STATUS_FULL, INDEX_W'(0), op_handle};
          end else if (op_func == FUNC_REMOVE) begin
            pend_valid_next = 1'b1;
            pend_next       = '{STATUS_NOT_FOUND, INDEX_W'(0), op_handle};
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_res_next    = pend;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ev_idx     <= '0;
      active     <= '0;
      fire_cnt   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ev_idx     <= ev_idx_next;
      active     <= active_next;
      fire_cnt   <= fire_cnt_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend     <= pend_next;
    out_res  <= out_res_next;
    out_last <= out_last_next;
    if (accept) begin
      op_func   <= s_tuser;
      op_handle <= s_tdata[15:0];
      op_due    <= s_tdata[47:16] + s_tdata[111:80];
      op_period <= s_tdata[79:48];
      op_now    <= s_tdata[111:80];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'b00000, out_res.handle, out_res.slot_index};

endmodule

// ===== rtl/ptst_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic timer slot table: port checker
// Watches the stream ports of the table and flags results that cannot occur.
// ----------------------------------------------------------------------------
`include "periodic_timer_slot_table_macros.svh"

module ptst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ptst_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [ptst_pkg::STATUS_W-1:0]    m_tuser,
  input logic                             m_tlast
);

  import ptst_pkg::*;

  // A result that is not taken stays unchanged.
  `PTST_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // The table works on one item at a time.
  `PTST_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)

  // Add and remove answers are always the only result of their item.
  `PTST_ASSERT_SAME(a_single_last, clk, rst, m_tvalid && (m_tuser != STATUS_FIRED), m_tlast)

  // Table full and not found name no slot.
  `PTST_ASSERT_SAME(a_miss_slot, clk, rst, m_tvalid && ((m_tuser == STATUS_FULL) || (m_tuser == STATUS_NOT_FOUND)), m_tdata[2:0] == 3'd0)

endmodule

bind periodic_timer_slot_table ptst_checker u_ptst_checker (.*);
